// ----- rtl/toh_pkg.sv -----
// ----------------------------------------------------------------------------
// toh_pkg
// Shared types and constants for the temperature outlier-hold filter.
// ----------------------------------------------------------------------------
package toh_pkg;

  localparam int TEMP_W    = 13;
  localparam int MAX_DEPTH = 16;
  localparam int DEPTH_DEF = 5;
  localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
  localparam int SUM_W     = TEMP_W + CNT_W;
  localparam int PROD_W    = TEMP_W + CNT_W + 1;
  localparam int DIFF_W    = PROD_W + 1;

  localparam logic signed [TEMP_W-1:0] TEMP_LIMIT = TEMP_W'(2550);
  localparam logic signed [TEMP_W-1:0] TEMP_EMPTY = -TEMP_W'(2550);

  typedef struct packed {
    logic signed [TEMP_W-1:0] reading;
    logic                     reading_valid;
  } in_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] filtered_temp;
    logic                     held_previous;
  } out_t;

  // running sum and count handed along the cell row
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        cnt;
  } chain_t;

endpackage

// ----- rtl/toh_cell.sv -----
// ----------------------------------------------------------------------------
// toh_cell
// One history entry: holds a sample and its mark, shifts on each beat and
// adds its sample to the running sum when it counts.
// ----------------------------------------------------------------------------
module toh_cell
  import toh_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     shift_en,
  input  logic signed [TEMP_W-1:0] value_in,
  input  logic                     mark_in,
  input  chain_t                   chain_in,
  output logic signed [TEMP_W-1:0] value_out,
  output logic                     mark_out,
  output chain_t                   chain_out
);

  logic signed [TEMP_W-1:0] value_r;
  logic                     mark_r;
  logic                     counted;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      value_r <= value_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r <= 1'b0;
    end else if (shift_en) begin
      mark_r <= mark_in;
    end
  end

  assign counted   = mark_r && (value_r > TEMP_EMPTY);
  assign value_out = value_r;
  assign mark_out  = mark_r;

  always_comb begin
    chain_out = chain_in;
    if (counted) begin
      chain_out.sum = chain_in.sum + {{(SUM_W-TEMP_W){value_r[TEMP_W-1]}}, value_r};
      chain_out.cnt = chain_in.cnt + CNT_W'(1);
    end
  end

endmodule

// ----- rtl/toh_judge.sv -----
// ----------------------------------------------------------------------------
// toh_judge
// Outlier test: hold when the sample is invalid or when
// |sum - n*cur| > |sum - n*prev|.
// ----------------------------------------------------------------------------
module toh_judge
  import toh_pkg::*;
(
  input  logic signed [TEMP_W-1:0] cur,
  input  logic                     cur_valid,
  input  logic signed [TEMP_W-1:0] prev,
  input  chain_t                   total,
  output logic                     hold
);

  logic signed [CNT_W:0]    n_s;
  logic signed [PROD_W-1:0] prod_cur;
  logic signed [PROD_W-1:0] prod_prev;
  logic signed [DIFF_W-1:0] sum_ext;
  logic signed [DIFF_W-1:0] diff_cur;
  logic signed [DIFF_W-1:0] diff_prev;
  logic [DIFF_W-1:0]        abs_cur;
  logic [DIFF_W-1:0]        abs_prev;

  assign n_s       = {1'b0, total.cnt};
  assign prod_cur  = PROD_W'(n_s) * PROD_W'(cur);
  assign prod_prev = PROD_W'(n_s) * PROD_W'(prev);
  assign sum_ext   = {{(DIFF_W-SUM_W){total.sum[SUM_W-1]}}, total.sum};
  assign diff_cur  = sum_ext - {{(DIFF_W-PROD_W){prod_cur[PROD_W-1]}}, prod_cur};
  assign diff_prev = sum_ext - {{(DIFF_W-PROD_W){prod_prev[PROD_W-1]}}, prod_prev};
  assign abs_cur   = diff_cur[DIFF_W-1]  ? DIFF_W'(-diff_cur)  : DIFF_W'(diff_cur);
  assign abs_prev  = diff_prev[DIFF_W-1] ? DIFF_W'(-diff_prev) : DIFF_W'(diff_prev);
  assign hold      = !cur_valid || (abs_cur > abs_prev);

endmodule

// ----- rtl/temperature_outlier_hold_filter.sv -----
// Output: a result is registered on out_ when its input beat is taken, or
// into the skid stage while out_ is stalled. Throughput: one beat per cycle
// while in_stall is low; the row's sum and the outlier test are combinational,
// and a skid stage keeps intake going for one beat while the output is stalled.
// Reset: synchronous, active low; history marks clear, last value = -2550.
// ----------------------------------------------------------------------------
// temperature_outlier_hold_filter
// Ring of recent samples as a row of shifting cells, averaged and compared
// against the last accepted value to hold off outliers.
// ----------------------------------------------------------------------------
module temperature_outlier_hold_filter
  import toh_pkg::*;
#(
  parameter int HISTORY_DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic                     in_acc;
  logic                     out_acc;
  logic signed [TEMP_W-1:0] cur;
  logic                     hold;
  out_t                     res;
  chain_t                   head_chain;

  logic signed [TEMP_W-1:0] last_r, last_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_t                     out_data_r, out_data_nxt;
  logic                     skid_valid_r, skid_valid_nxt;
  out_t                     skid_data_r, skid_data_nxt;

  logic signed [TEMP_W-1:0] sh_value [HISTORY_DEPTH];
  logic                     sh_mark  [HISTORY_DEPTH];
  chain_t                   chain    [HISTORY_DEPTH];

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;

  always_comb begin
    if (in_data.reading > TEMP_LIMIT) begin
      cur = TEMP_LIMIT;
    end else if (in_data.reading < TEMP_EMPTY) begin
      cur = TEMP_EMPTY;
    end else begin
      cur = in_data.reading;
    end
  end

  // head of the row: the new sample
  assign sh_value[0] = cur;
  assign sh_mark[0]  = in_data.reading_valid;

  always_comb begin
    head_chain = '0;
    if (in_data.reading_valid && (cur > TEMP_EMPTY)) begin
      head_chain.sum = {{(SUM_W-TEMP_W){cur[TEMP_W-1]}}, cur};
      head_chain.cnt = CNT_W'(1);
    end
  end

  assign chain[0] = head_chain;

  for (genvar i = 0; i < HISTORY_DEPTH - 1; i++) begin : g_cell
    toh_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift_en  (in_acc),
      .value_in  (sh_value[i]),
      .mark_in   (sh_mark[i]),
      .chain_in  (chain[i]),
      .value_out (sh_value[i+1]),
      .mark_out  (sh_mark[i+1]),
      .chain_out (chain[i+1])
    );
  end

  toh_judge u_judge (
    .cur       (cur),
    .cur_valid (in_data.reading_valid),
    .prev      (last_r),
    .total     (chain[HISTORY_DEPTH-1]),
    .hold      (hold)
  );

  always_comb begin
    res.filtered_temp = hold ? last_r : cur;
    res.held_previous = hold;
  end

  always_comb begin
    last_nxt       = last_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (in_acc && !hold) begin
      last_nxt = cur;
    end
    if (skid_valid_r) begin
      if (out_acc) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_acc) begin
      if (out_valid_r && out_stall) begin
        skid_data_nxt  = res;
        skid_valid_nxt = 1'b1;
      end else begin
        out_data_nxt  = res;
        out_valid_nxt = 1'b1;
      end
    end else if (out_acc) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r       <= TEMP_EMPTY;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      last_r       <= last_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid beat held without output beat");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_acc) |=> (out_valid_r && !skid_valid_r))
    else $error("skid beat not moved to output");

  a_hold_keeps_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_data.reading_valid) |=> $stable(last_r))
    else $error("invalid sample changed last accepted value");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    chain[HISTORY_DEPTH-1].cnt <= CNT_W'(HISTORY_DEPTH))
    else $error("history count exceeds depth");
`endif

endmodule
